// File: rtl/acp_pkg.sv
// acp_pkg: types, codes and helpers shared by the arp cache table
// no dependencies; used by acp_entry_store and arp_cache_table
package acp_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } acp_state_type;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_FOUND   = 3'd0;
   localparam status_type STATUS_MISS    = 3'd1;
   localparam status_type STATUS_QUEUED  = 3'd2;
   localparam status_type STATUS_UPDATED = 3'd3;
   localparam status_type STATUS_NEW     = 3'd4;

   localparam logic CMD_LOOKUP   = 1'b0;
   localparam logic CMD_REGISTER = 1'b1;

   localparam logic [15:0] LIFE_PERMANENT = 16'hFFFF;
   localparam logic [15:0] LIFE_MIN       = 16'd1;
   localparam logic [15:0] LIFE_RESET     = 16'd300;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] lifetime;
      logic        permanent;
   } entry_type;

   function automatic logic [15:0] life_value(input logic perm, input logic [15:0] dyn);
      logic [15:0] life;
      if (perm) begin
         life = LIFE_PERMANENT;
      end else if (dyn == 16'd0) begin
         life = LIFE_MIN;
      end else begin
         life = dyn;
      end
      return life;
   endfunction

endpackage

// File: rtl/arp_cache_table.sv
// arp_cache_table: ipv4-to-mac cache with round-robin replacement
// depends on acp_pkg and acp_entry_store
//
//   channel   ports                 direction   transfer
//   req       req_valid/req_ready   in          one item per lookup or register
//   rsp       rsp_valid/rsp_ready   out         one item per request
//   csr       csr_write_enable      in          dynamic_lifetime, no wait
//
// the entry memory is walked one address per cycle in index order, stopping at the
// first matching valid entry, then the entry is written back and the result register
// is loaded.
// synchronous reset clears valid bits, victim pointer and handshake state.
// a new item is taken while the last result waits; write-back stalls while the
// result register is still full.
module arp_cache_table import acp_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int PENDING_MAX   = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_ip_address,
   input  logic [47:0] req_mac_address_in,
   input  logic        req_is_permanent,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [47:0] rsp_mac_address_out,
   output logic [3:0]  rsp_entry_index,
   output logic [3:0]  rsp_released_frames,
   output logic [3:0]  rsp_dropped_frames,
   output logic        rsp_queue_full,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int PEND_W = $clog2(PENDING_MAX + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(PENDING_MAX);

   acp_state_type     state_ff, state_in;
   logic              cmd_ff;
   logic [31:0]       ip_ff;
   logic [47:0]       mac_ff;
   logic              perm_ff;
   logic [15:0]       dyn_life_ff;
   logic [IDX_W-1:0]  scan_addr_ff;
   logic              issue_done_ff;
   logic              chk_valid_ff;
   logic [IDX_W-1:0]  chk_addr_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  victim_ff;
   entry_type         cap_entry_ff;
   logic [PEND_W-1:0] cap_pend_ff;

   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic [47:0]       mac_out_ff, mac_out_in;
   logic [3:0]        index_ff, index_in;
   logic [3:0]        released_ff, released_in;
   logic [3:0]        dropped_ff, dropped_in;
   logic              full_ff, full_in;

   logic              accept;
   logic              rd_en;
   entry_type         rd_entry;
   logic [PEND_W-1:0] rd_pend;
   logic              rd_valid;
   logic              match;
   logic              last_chk;
   logic              fire;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_entry;
   logic [PEND_W-1:0] wr_pend;
   logic [IDX_W+3:0]  index_wide;
   logic [PEND_W+3:0] released_wide;
   logic [PEND_W+3:0] dropped_wide;

   acp_entry_store #(
      .DEPTH  (TABLE_ENTRIES),
      .PEND_W (PEND_W),
      .IDX_W  (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (scan_addr_ff),
      .rd_entry (rd_entry),
      .rd_pend  (rd_pend),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .wr_pend  (wr_pend)
   );

   assign accept   = req_valid && req_ready;
   assign match    = chk_valid_ff && rd_valid && (rd_entry.ip == ip_ff);
   assign last_chk = chk_valid_ff && (chk_addr_ff == LAST_IDX);
   assign fire     = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match || last_chk) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   rd_en     = !issue_done_ff;
         ST_UPDATE: wr_en     = fire;
         default:   req_ready = 1'b0;
      endcase
   end

   // write-back and result
   always_comb begin
      wr_addr     = hit_ff ? idx_ff : victim_ff;
      wr_entry    = cap_entry_ff;
      wr_pend     = cap_pend_ff;
      status_in   = STATUS_FOUND;
      mac_out_in  = 48'd0;
      released_wide = '0;
      dropped_wide  = '0;
      full_in     = 1'b0;
      if (hit_ff) begin
         if (cmd_ff == CMD_LOOKUP) begin
            if (cap_pend_ff == '0) begin
               status_in  = STATUS_FOUND;
               mac_out_in = cap_entry_ff.mac;
            end else begin
               status_in = STATUS_QUEUED;
               if (cap_pend_ff >= PEND_MAX) begin
                  full_in = 1'b1;
               end else begin
                  wr_pend = cap_pend_ff + PEND_W'(1);
               end
            end
         end else begin
            status_in          = STATUS_UPDATED;
            wr_entry.mac       = mac_ff;
            wr_entry.lifetime  = life_value(perm_ff, dyn_life_ff);
            wr_entry.permanent = perm_ff;
            wr_pend            = '0;
            released_wide      = {4'd0, cap_pend_ff};
         end
      end else begin
         dropped_wide = {4'd0, cap_pend_ff};
         wr_entry.ip  = ip_ff;
         if (cmd_ff == CMD_LOOKUP) begin
            status_in          = STATUS_MISS;
            wr_entry.lifetime  = life_value(1'b0, dyn_life_ff);
            wr_entry.permanent = 1'b0;
            wr_pend            = PEND_W'(1);
         end else begin
            status_in          = STATUS_NEW;
            wr_entry.mac       = mac_ff;
            wr_entry.lifetime  = life_value(perm_ff, dyn_life_ff);
            wr_entry.permanent = perm_ff;
            wr_pend            = '0;
         end
      end
      index_wide  = {4'd0, wr_addr};
      index_in    = index_wide[3:0];
      released_in = released_wide[3:0];
      dropped_in  = dropped_wide[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dyn_life_ff   <= LIFE_RESET;
         victim_ff     <= '0;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            dyn_life_ff <= csr_write_data;
         end
         if (accept) begin
            issue_done_ff <= 1'b0;
            chk_valid_ff  <= 1'b0;
            hit_ff        <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            chk_valid_ff <= rd_en;
            if (rd_en && (scan_addr_ff == LAST_IDX)) begin
               issue_done_ff <= 1'b1;
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
         end
         if (wr_en) begin
            rsp_valid_ff <= 1'b1;
            if (!hit_ff) begin
               victim_ff <= (victim_ff == LAST_IDX) ? '0 : victim_ff + IDX_W'(1);
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_command;
         ip_ff        <= req_ip_address;
         mac_ff       <= req_mac_address_in;
         perm_ff      <= req_is_permanent;
         scan_addr_ff <= '0;
      end else if (rd_en) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
      if (rd_en) begin
         chk_addr_ff <= scan_addr_ff;
      end
      if (state_ff == ST_SCAN) begin
         if (match) begin
            idx_ff       <= chk_addr_ff;
            cap_entry_ff <= rd_entry;
            cap_pend_ff  <= rd_pend;
         end else if (chk_valid_ff && (chk_addr_ff == victim_ff)) begin
            cap_entry_ff <= rd_entry;
            cap_pend_ff  <= rd_pend;
         end
      end
      if (wr_en) begin
         status_ff   <= status_in;
         mac_out_ff  <= mac_out_in;
         index_ff    <= index_in;
         released_ff <= released_in;
         dropped_ff  <= dropped_in;
         full_ff     <= full_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_mac_address_out = mac_out_ff;
   assign rsp_entry_index     = index_ff;
   assign rsp_released_frames = released_ff;
   assign rsp_dropped_frames  = dropped_ff;
   assign rsp_queue_full      = full_ff;

endmodule

// File: rtl/acp_entry_store.sv
// acp_entry_store: entry memory and pending-count memory, registered read outputs
// valid bit per entry; an entry never written reads as invalid with no frames waiting
// depends on acp_pkg
module acp_entry_store import acp_pkg::*; #(
   parameter int DEPTH  = 16,
   parameter int PEND_W = 4,
   parameter int IDX_W  = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output entry_type         rd_entry,
   output logic [PEND_W-1:0] rd_pend,
   output logic              rd_valid,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  entry_type         wr_entry,
   input  logic [PEND_W-1:0] wr_pend
);

   entry_type         entry_mem [DEPTH];
   logic [PEND_W-1:0] pend_mem  [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   entry_type         rd_entry_ff;
   logic [PEND_W-1:0] rd_pend_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
         pend_mem[wr_addr]  <= wr_pend;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
         rd_pend_ff  <= pend_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;
   assign rd_pend  = rd_valid_ff ? rd_pend_ff : '0;

endmodule

// File: tb/arp_cache_table_tb.sv
`timescale 1ns / 1ps
// arp_cache_table_tb: self-checking bench for the arp cache table, directed rows then random
// traffic over several lifetime settings, answers held to the script or a local cache model
// depends on acp_pkg and arp_cache_table
module arp_cache_table_tb import acp_pkg::*;;

   localparam int TABLE_ENTRIES = 16;
   localparam int PENDING_MAX   = 15;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 130;
   localparam int PHASES        = 5;
   localparam int SCRIPT_ROWS   = 11;

   typedef struct packed {
      status_type  status;
      logic [47:0] mac;
      logic [3:0]  index;
      logic [3:0]  released;
      logic [3:0]  dropped;
      logic        full;
   } arp_answer_type;

   typedef struct {
      logic           cmd;
      logic [31:0]    ip;
      logic [47:0]    mac;
      logic           perm;
      int             reps;
      logic           typed;
      arp_answer_type answer;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_LOOKUP;
   logic [31:0] req_ip_address = '0;
   logic [47:0] req_mac_address_in = '0;
   logic        req_is_permanent = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [47:0] rsp_mac_address_out;
   logic [3:0]  rsp_entry_index;
   logic [3:0]  rsp_released_frames;
   logic [3:0]  rsp_dropped_frames;
   logic        rsp_queue_full;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   // cache model state
   logic [31:0] cache_ip [TABLE_ENTRIES];
   logic [47:0] cache_mac [TABLE_ENTRIES];
   logic [15:0] cache_life [TABLE_ENTRIES];
   logic        cache_perm [TABLE_ENTRIES];
   logic [3:0]  cache_waiting [TABLE_ENTRIES];
   logic [3:0]  next_victim = '0;
   logic [15:0] lifetime_setting = LIFE_RESET;

   arp_answer_type answers_due [$];
   int          mismatches = 0;
   int          requests_sent = 0;
   int          answers_checked = 0;
   int          full_seen = 0;
   int          drops_seen = 0;
   int          cycle_count = 0;
   logic        calm = 1'b0;

   script_row_type script [SCRIPT_ROWS] = '{
      '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 1'b0, 1, 1'b1,
        '{STATUS_MISS, 48'h0, 4'd0, 4'd0, 4'd0, 1'b0}},
      '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 1'b0, 14, 1'b0, '0},
      '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 1'b1, 1, 1'b1,
        '{STATUS_QUEUED, 48'h0, 4'd0, 4'd0, 4'd0, 1'b1}},
      '{CMD_REGISTER, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0, 1, 1'b1,
        '{STATUS_UPDATED, 48'h0, 4'd0, 4'd15, 4'd0, 1'b0}},
      '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 1'b0, 1, 1'b1,
        '{STATUS_FOUND, 48'hFFFF_FFFF_FFFF, 4'd0, 4'd0, 4'd0, 1'b0}},
      '{CMD_REGISTER, 32'hFFFF_FFFF, 48'h0, 1'b1, 1, 1'b1,
        '{STATUS_NEW, 48'h0, 4'd1, 4'd0, 4'd0, 1'b0}},
      '{CMD_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1, 1'b1,
        '{STATUS_FOUND, 48'h0, 4'd1, 4'd0, 4'd0, 1'b0}},
      '{CMD_REGISTER, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 1'b0, 1, 1'b0, '0},
      '{CMD_REGISTER, 32'h0000_0000, 48'hAAAA_AAAA_AAAA, 1'b1, 1, 1'b0, '0},
      '{CMD_LOOKUP, 32'hC0A8_0001, 48'h0, 1'b0, 1, 1'b0, '0},
      '{CMD_REGISTER, 32'hC0A8_0001, 48'h5555_5555_5555, 1'b0, 1, 1'b0, '0}
   };

   arp_cache_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .PENDING_MAX(PENDING_MAX)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_ip_address(req_ip_address),
      .req_mac_address_in(req_mac_address_in),
      .req_is_permanent(req_is_permanent),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_mac_address_out(rsp_mac_address_out),
      .rsp_entry_index(rsp_entry_index),
      .rsp_released_frames(rsp_released_frames),
      .rsp_dropped_frames(rsp_dropped_frames),
      .rsp_queue_full(rsp_queue_full),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         cache_ip[k] = '0;
         cache_mac[k] = '0;
         cache_life[k] = '0;
         cache_perm[k] = 1'b0;
         cache_waiting[k] = '0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic arp_answer_type resolve_request(input logic cmd, input logic [31:0] ip,
                                                      input logic [47:0] mac, input logic perm);
      arp_answer_type ans;
      int          hit;
      int          k;
      logic [3:0]  slot;
      logic [15:0] dyn_life;
      ans = '0;
      hit = -1;
      dyn_life = (lifetime_setting == 16'd0) ? LIFE_MIN : lifetime_setting;
      // first valid match in index order wins
      for (k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (cache_life[k] != 16'd0 && cache_ip[k] == ip) begin
            hit = k;
         end
      end
      if (hit >= 0) begin
         slot = 4'(hit);
         if (cmd == CMD_LOOKUP) begin
            if (cache_waiting[slot] == 4'd0) begin
               ans.status = STATUS_FOUND;
               ans.mac = cache_mac[slot];
            end else begin
               ans.status = STATUS_QUEUED;
               if (cache_waiting[slot] >= 4'(PENDING_MAX)) begin
                  ans.full = 1'b1;
               end else begin
                  cache_waiting[slot] = cache_waiting[slot] + 4'd1;
               end
            end
         end else begin
            ans.status = STATUS_UPDATED;
            cache_mac[slot] = mac;
            cache_life[slot] = perm ? LIFE_PERMANENT : dyn_life;
            cache_perm[slot] = perm;
            ans.released = cache_waiting[slot];
            cache_waiting[slot] = '0;
         end
      end else begin
         slot = next_victim;
         next_victim = 4'((int'(next_victim) + 1) % TABLE_ENTRIES);
         ans.dropped = cache_waiting[slot];
         cache_ip[slot] = ip;
         if (cmd == CMD_LOOKUP) begin
            ans.status = STATUS_MISS;
            cache_life[slot] = dyn_life;
            cache_perm[slot] = 1'b0;
            cache_waiting[slot] = 4'd1;
         end else begin
            ans.status = STATUS_NEW;
            cache_mac[slot] = mac;
            cache_life[slot] = perm ? LIFE_PERMANENT : dyn_life;
            cache_perm[slot] = perm;
            cache_waiting[slot] = '0;
         end
      end
      ans.index = slot;
      return ans;
   endfunction

   task automatic compare_field(input string label, input logic [47:0] want,
                                input logic [47:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", label, want, got);
         mismatches++;
      end
   endtask

   task automatic send_request(input logic cmd, input logic [31:0] ip, input logic [47:0] mac,
                               input logic perm, input logic typed,
                               input arp_answer_type typed_answer);
      arp_answer_type predicted;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_ip_address <= ip;
      req_mac_address_in <= mac;
      req_is_permanent <= perm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = resolve_request(cmd, ip, mac, perm);
      answers_due.push_back(typed ? typed_answer : predicted);
      requests_sent++;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_for_answers();
      repeat (TABLE_ENTRIES + 6) @(posedge clock);
   endtask

   task automatic pace_sender();
      if (!calm && $urandom_range(0, 59) == 0) begin
         wait_for_answers();
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // answer side: check each item, stall in random bursts
   initial begin : answer_checker
      arp_answer_type want;
      int          stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("unexpected item: status %0d, entry %0d", rsp_status, rsp_entry_index);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               answers_checked++;
               compare_field("status", 48'(want.status), 48'(rsp_status));
               compare_field("mac_address_out", want.mac, rsp_mac_address_out);
               compare_field("entry_index", 48'(want.index), 48'(rsp_entry_index));
               compare_field("released_frames", 48'(want.released), 48'(rsp_released_frames));
               compare_field("dropped_frames", 48'(want.dropped), 48'(rsp_dropped_frames));
               compare_field("queue_full", 48'(want.full), 48'(rsp_queue_full));
               if (want.full) full_seen++;
               if (want.dropped != 4'd0) drops_seen++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : request_driver
      logic [15:0] lifetime_steps [3];
      logic [31:0] ip_pool [32];
      logic [31:0] burst_ip;
      logic [31:0] ip;
      logic [63:0] wide;
      logic [15:0] setting;
      logic        cmd;
      logic        perm;
      arp_answer_type none;
      int          phase;
      int          pool_size;
      int          burst_left;
      int          n;
      int          k;
      int          r;
      lifetime_steps = '{16'd0, 16'hFFFF, 16'd1};
      none = '0;
      burst_ip = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         for (k = 0; k < script[i].reps; k++) begin
            send_request(script[i].cmd, script[i].ip, script[i].mac, script[i].perm,
                         script[i].typed, script[i].answer);
            pace_sender();
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            setting = (phase == PHASES - 1) ? 16'($urandom_range(2, 65534))
                                            : lifetime_steps[phase - 1];
            csr_write_enable <= 1'b1;
            csr_write_data <= setting;
            lifetime_setting = setting;
            @(posedge clock);
            csr_write_enable <= 1'b0;
         end
         calm = (phase == PHASES - 1);
         pool_size = $urandom_range(4, 28);
         for (k = 0; k < pool_size; k++) begin
            ip_pool[k] = $urandom;
         end
         burst_left = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            wide = {$urandom, $urandom};
            perm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (burst_left > 0) begin
               // repeated sends to one address to fill its waiting count
               cmd = CMD_LOOKUP;
               ip = burst_ip;
               burst_left--;
            end else if (r < 4) begin
               burst_ip = ip_pool[$urandom_range(0, pool_size - 1)];
               burst_left = $urandom_range(10, 20);
               cmd = CMD_LOOKUP;
               ip = burst_ip;
            end else if (r < 14) begin
               cmd = 1'($urandom_range(0, 1));
               ip = $urandom;
            end else begin
               cmd = ($urandom_range(0, 9) < 6) ? CMD_LOOKUP : CMD_REGISTER;
               ip = ip_pool[$urandom_range(0, pool_size - 1)];
            end
            send_request(cmd, ip, wide[47:0], perm, 1'b0, none);
            pace_sender();
         end
      end

      settle();
      $display("sent %0d requests over %0d lifetime settings, checked %0d answers",
               requests_sent, PHASES, answers_checked);
      $display("saturated queue hit %0d times, victims with dropped frames %0d times",
               full_seen, drops_seen);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/acp_pkg.sv
rtl/acp_entry_store.sv
rtl/arp_cache_table.sv
tb/arp_cache_table_tb.sv
